// ===== rtl/rope_sc_pkg.sv =====
// ----------------------------------------------------------------------------
// rope_sc_pkg
// Shared widths, sizes and build-time tables of the rotary sin/cos table
// generator: frequency rom (q0.40 turns per position) and series divisors.
// ----------------------------------------------------------------------------
package rope_sc_pkg;

  localparam int unsigned HEAD_SIZE  = 128;
  localparam longint unsigned THETA  = 1000000;
  localparam int unsigned HALF_DIM   = HEAD_SIZE / 2;
  localparam int unsigned DIDX_W     = (HALF_DIM > 1) ? $clog2(HALF_DIM) : 1;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned FREQ_IDX_W = 6;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned PHASE_W    = 40;
  localparam int unsigned NTERMS     = 6;

  localparam logic [DIDX_W-1:0] LAST_DIDX = DIDX_W'(HALF_DIM - 1);

  localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] ONE_Q62    = 64'h4000_0000_0000_0000;
  localparam logic [63:0] ROM_TARGET = ONE_Q62 / 64'(THETA);

  typedef logic [PHASE_W-1:0]        freq_t;
  typedef freq_t [HALF_DIM-1:0]      freq_rom_t;
  typedef logic [NTERMS-1:0][7:0]    div_tab_t;
  typedef logic [NTERMS-1:0][63:0]   magic_tab_t;

  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int unsigned s);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return 64'(p >> s);
  endfunction

  function automatic logic [63:0] power_q62(logic [63:0] b);
    logic [63:0] r;
    r = ONE_Q62;
    for (int i = 0; i < HEAD_SIZE; i++) begin
      r = mul_shr(r, b, 62);
    end
    return r;
  endfunction

  function automatic freq_rom_t build_rom();
    freq_rom_t   rom;
    logic [63:0] b;
    logic [63:0] cand;
    logic [63:0] rem;
    logic [63:0] recip;
    logic [63:0] g;
    rom   = '0;
    b     = '0;
    rem   = 64'h1000_0000_0000_0000;
    recip = '0;
    g     = ONE_Q62;
    for (int bit_i = 61; bit_i >= 0; bit_i--) begin
      cand = b | (64'd1 << bit_i);
      if (power_q62(cand) <= ROM_TARGET) begin
        b = cand;
      end
    end
    for (int i = 0; i < 64; i++) begin
      rem   = rem << 1;
      recip = recip << 1;
      if (rem >= TWO_PI_Q60) begin
        rem      = rem - TWO_PI_Q60;
        recip[0] = 1'b1;
      end
    end
    for (int d = 0; d < HALF_DIM; d++) begin
      rom[d] = PHASE_W'((mul_shr(g, recip, 85) + 64'd1) >> 1);
      g      = mul_shr(mul_shr(g, b, 62), b, 62);
    end
    return rom;
  endfunction

  // divisors of the sine and cosine terms
  function automatic div_tab_t make_div(logic is_sin);
    div_tab_t t;
    t = '0;
    for (int i = 0; i < NTERMS; i++) begin
      if (is_sin) begin
        t[i] = 8'((2 * i + 2) * (2 * i + 3));
      end else begin
        t[i] = 8'((2 * i + 1) * (2 * i + 2));
      end
    end
    return t;
  endfunction

  // floor(2^64 / k) by long division
  function automatic logic [63:0] recip_floor(logic [7:0] k);
    logic [8:0]  rem;
    logic [64:0] q;
    rem = '0;
    q   = '0;
    for (int j = 64; j >= 0; j--) begin
      rem = {rem[7:0], (j == 64)};
      if (rem >= {1'b0, k}) begin
        rem  = rem - {1'b0, k};
        q[j] = 1'b1;
      end
    end
    return q[63:0];
  endfunction

  function automatic magic_tab_t make_magic(div_tab_t t);
    magic_tab_t m;
    m = '0;
    for (int i = 0; i < NTERMS; i++) begin
      m[i] = recip_floor(t[i]);
    end
    return m;
  endfunction

  localparam freq_rom_t  FREQ_ROM  = build_rom();
  localparam div_tab_t   SIN_DIV   = make_div(1'b1);
  localparam div_tab_t   COS_DIV   = make_div(1'b0);
  localparam magic_tab_t SIN_MAGIC = make_magic(SIN_DIV);
  localparam magic_tab_t COS_MAGIC = make_magic(COS_DIV);

endpackage

// ===== rtl/rope_sc_in_if.sv =====
// ----------------------------------------------------------------------------
// rope_sc_in_if
// Row index channel: valid/ready handshake carrying one position index.
// ----------------------------------------------------------------------------
interface rope_sc_in_if;

  logic                           valid;
  logic                           ready;
  logic [rope_sc_pkg::POS_W-1:0]  position_index;

  modport source (output valid, output position_index, input ready);
  modport sink   (input valid, input position_index, output ready);

endinterface

// ===== rtl/rope_sc_out_if.sv =====
// ----------------------------------------------------------------------------
// rope_sc_out_if
// Result channel: valid/ready handshake carrying one cos/sin pair per
// frequency index.
// ----------------------------------------------------------------------------
interface rope_sc_out_if;

  logic                                 valid;
  logic                                 ready;
  logic [rope_sc_pkg::FREQ_IDX_W-1:0]   freq_index;
  logic signed [rope_sc_pkg::VAL_W-1:0] cos_value;
  logic signed [rope_sc_pkg::VAL_W-1:0] sin_value;
  logic                                 last_of_row;

  modport source (output valid, output freq_index, output cos_value, output sin_value,
                  output last_of_row, input ready);
  modport sink   (input valid, input freq_index, input cos_value, input sin_value,
                  input last_of_row, output ready);

endinterface

// ===== rtl/rope_sin_cos_table_generator_top.sv =====
// ----------------------------------------------------------------------------
// rope_sin_cos_table_generator_top
// Rotary embedding sin/cos table generator: one row index in, one q1.15
// cos/sin pair out for every frequency index of the half head.
//
//   channel   dir  handshake          payload
//   req_i     in   valid/ready        position_index
//   res_o     out  valid/ready        freq_index, cos_value, sin_value, last_of_row
//   cfg       in   cfg_we_i           cfg_wdata_i (position offset)
//
// A row index is taken when no row is in progress or in the cycle its last
// frequency issues; one frequency issues per cycle while the result is not
// stalled, stepped by the frequency counter feeding the pipeline.
// Reset clears the offset, the row counter and every pipeline valid bit.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rope_sin_cos_table_generator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rope_sc_pkg::POS_W-1:0]  cfg_wdata_i,
  rope_sc_in_if.sink                     req_i,
  rope_sc_out_if.source                  res_o
);

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_e;

  typedef struct packed {
    logic                            vld;
    logic [rope_sc_pkg::DIDX_W-1:0]  didx;
    quad_e                           quad;
    logic                            swap;
  } ctl_t;

  typedef struct packed {
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } pp_t;

  typedef struct packed {
    ctl_t                ctl;
    logic [16:0]         pos;
    rope_sc_pkg::freq_t  freq;
  } rom_st_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [39:0] phase;
  } phase_st_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [37:0] v;
  } fold_st_t;

  typedef struct packed {
    ctl_t ctl;
    pp_t  pp;
  } xpp_st_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] x;
  } x_st_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] x;
    pp_t         pp;
  } sq_st_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] x2;
    logic [63:0] ss;
    logic [63:0] sc;
    logic [63:0] ts;
    logic [63:0] tc;
  } ser_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] x2;
    logic [63:0] ss;
    logic [63:0] sc;
    pp_t         ps;
    pp_t         pc;
  } mul_st_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] x2;
    logic [63:0] ss;
    logic [63:0] sc;
    logic [63:0] ms;
    logic [63:0] mc;
  } prod_st_t;

  typedef struct packed {
    prod_st_t p;
    pp_t      ps;
    pp_t      pc;
  } qpp_st_t;

  typedef struct packed {
    prod_st_t    p;
    logic [63:0] qs;
    logic [63:0] qc;
  } quo_st_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] ss;
    logic [63:0] sc;
  } acc_st_t;

  typedef struct packed {
    logic                            vld;
    logic [rope_sc_pkg::DIDX_W-1:0]  didx;
    logic [16:0]                     cm;
    logic                            cn;
    logic [16:0]                     sm;
    logic                            sn;
  } rnd_st_t;

  localparam logic [38:0] QUARTER_TURN = 39'h40_0000_0000;
  localparam logic [37:0] EIGHTH_TURN  = 38'h20_0000_0000;
  localparam logic [63:0] ROUND_HALF   = 64'h0000_4000_0000_0000;
  localparam logic        LAST_SUB     = 1'(rope_sc_pkg::NTERMS % 2);

  function automatic pp_t pp_mul(logic [63:0] a, logic [63:0] b);
    pp_t pp;
    pp.p00 = 64'(a[31:0]) * 64'(b[31:0]);
    pp.p01 = 64'(a[31:0]) * 64'(b[63:32]);
    pp.p10 = 64'(a[63:32]) * 64'(b[31:0]);
    pp.p11 = 64'(a[63:32]) * 64'(b[63:32]);
    return pp;
  endfunction

  function automatic logic [63:0] pp_shr(pp_t pp, int unsigned sh);
    logic [127:0] s;
    s = {64'b0, pp.p00} + {32'b0, pp.p01, 32'b0} + {32'b0, pp.p10, 32'b0} + {pp.p11, 64'b0};
    return 64'(s >> sh);
  endfunction

  function automatic logic [63:0] accum(logic [63:0] acc, logic [63:0] term, logic sub);
    return sub ? (acc - term) : (acc + term);
  endfunction

  // quotient estimate is exact or one low
  function automatic logic [63:0] correct(logic [63:0] q0, logic [63:0] v, logic [7:0] k);
    logic [9:0] r;
    r = v[9:0] - 10'({2'b0, k} * q0[9:0]);
    return (r >= {2'b0, k}) ? (q0 + 64'd1) : q0;
  endfunction

  function automatic logic [15:0] to_q15(logic [16:0] m, logic neg);
    logic [16:0] mc;
    mc = (m > 17'd32768) ? 17'd32768 : m;
    if (neg) begin
      return 16'(17'h1_0000 - mc);
    end
    return (mc > 17'd32767) ? 16'h7FFF : mc[15:0];
  endfunction

  // configuration and row sequencing
  logic [rope_sc_pkg::POS_W-1:0]   offset_q;
  logic                            busy_q;
  logic [rope_sc_pkg::DIDX_W-1:0]  didx_q;
  logic [16:0]                     pos_q;
  logic                            en;
  logic                            in_fire;
  logic                            row_last;

  // pipeline
  rom_st_t   rom_q;
  phase_st_t phase_q;
  fold_st_t  fold_q;
  xpp_st_t   xpp_q;
  x_st_t     x_q;
  sq_st_t    sq_q;
  ser_t      ser_q  [rope_sc_pkg::NTERMS+1];
  mul_st_t   mul_q  [rope_sc_pkg::NTERMS];
  prod_st_t  prod_q [rope_sc_pkg::NTERMS];
  qpp_st_t   qpp_q  [rope_sc_pkg::NTERMS];
  quo_st_t   quo_q  [rope_sc_pkg::NTERMS];
  acc_st_t   acc_q;
  rnd_st_t   rnd_q;

  logic [56:0]  phase_prod;
  logic [37:0]  fold_u;
  logic         fold_big;
  logic [38:0]  fold_diff;
  logic [63:0]  s0;
  logic [63:0]  c0;
  logic [63:0]  cm_mag;
  logic [63:0]  sm_mag;
  logic         cm_neg;
  logic         sm_neg;

  // output register
  logic                                 out_vld_q;
  logic [rope_sc_pkg::FREQ_IDX_W-1:0]   freq_idx_q;
  logic signed [rope_sc_pkg::VAL_W-1:0] cos_q;
  logic signed [rope_sc_pkg::VAL_W-1:0] sin_q;
  logic                                 last_q;

  assign en       = !out_vld_q || res_o.ready;
  assign row_last = (didx_q == rope_sc_pkg::LAST_DIDX);
  assign in_fire  = req_i.valid && req_i.ready;

  assign req_i.ready = !busy_q || (en && row_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      didx_q <= '0;
      pos_q  <= '0;
    end else if (in_fire) begin
      busy_q <= 1'b1;
      didx_q <= '0;
      pos_q  <= {1'b0, req_i.position_index} + {1'b0, offset_q};
    end else if (busy_q && en) begin
      if (row_last) begin
        busy_q <= 1'b0;
      end else begin
        didx_q <= didx_q + rope_sc_pkg::DIDX_W'(1);
      end
    end
  end

  assign phase_prod = {40'b0, rom_q.pos} * {17'b0, rom_q.freq};
  assign fold_u     = phase_q.phase[37:0];
  assign fold_big   = fold_u > EIGHTH_TURN;
  assign fold_diff  = QUARTER_TURN - {1'b0, fold_u};

  // octant swap then quadrant rotation
  always_comb begin
    s0 = acc_q.ctl.swap ? acc_q.sc : acc_q.ss;
    c0 = acc_q.ctl.swap ? acc_q.ss : acc_q.sc;
    case (acc_q.ctl.quad)
      QUAD_I: begin
        cm_mag = c0; cm_neg = 1'b0; sm_mag = s0; sm_neg = 1'b0;
      end
      QUAD_II: begin
        cm_mag = s0; cm_neg = 1'b1; sm_mag = c0; sm_neg = 1'b0;
      end
      QUAD_III: begin
        cm_mag = c0; cm_neg = 1'b1; sm_mag = s0; sm_neg = 1'b1;
      end
      default: begin
        cm_mag = s0; cm_neg = 1'b0; sm_mag = c0; sm_neg = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q   <= '0;
      phase_q <= '0;
      fold_q  <= '0;
      xpp_q   <= '0;
      x_q     <= '0;
      sq_q    <= '0;
      for (int i = 0; i <= rope_sc_pkg::NTERMS; i++) begin
        ser_q[i] <= '0;
      end
      for (int i = 0; i < rope_sc_pkg::NTERMS; i++) begin
        mul_q[i]  <= '0;
        prod_q[i] <= '0;
        qpp_q[i]  <= '0;
        quo_q[i]  <= '0;
      end
      acc_q     <= '0;
      rnd_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      rom_q.ctl  <= '{vld: busy_q, didx: didx_q, quad: QUAD_I, swap: 1'b0};
      rom_q.pos  <= pos_q;
      rom_q.freq <= rope_sc_pkg::FREQ_ROM[didx_q];

      phase_q.ctl   <= rom_q.ctl;
      phase_q.phase <= phase_prod[39:0];

      fold_q.ctl <= '{vld: phase_q.ctl.vld, didx: phase_q.ctl.didx,
                      quad: quad_e'(phase_q.phase[39:38]), swap: fold_big};
      fold_q.v   <= fold_big ? fold_diff[37:0] : fold_u;

      xpp_q.ctl <= fold_q.ctl;
      xpp_q.pp  <= pp_mul({26'b0, fold_q.v}, rope_sc_pkg::TWO_PI_Q60);

      x_q.ctl <= xpp_q.ctl;
      x_q.x   <= pp_shr(xpp_q.pp, 38);

      sq_q.ctl <= x_q.ctl;
      sq_q.x   <= x_q.x;
      sq_q.pp  <= pp_mul(x_q.x, x_q.x);

      ser_q[0].ctl <= sq_q.ctl;
      ser_q[0].x2  <= pp_shr(sq_q.pp, 62);
      ser_q[0].ss  <= sq_q.x;
      ser_q[0].ts  <= sq_q.x;
      ser_q[0].sc  <= rope_sc_pkg::ONE_Q62;
      ser_q[0].tc  <= rope_sc_pkg::ONE_Q62;

      // one series term per five stages: multiply by x^2, then divide
      for (int i = 0; i < rope_sc_pkg::NTERMS; i++) begin
        mul_q[i].ctl <= ser_q[i].ctl;
        mul_q[i].x2  <= ser_q[i].x2;
        mul_q[i].ss  <= (i > 0) ? accum(ser_q[i].ss, ser_q[i].ts, 1'(i % 2)) : ser_q[i].ss;
        mul_q[i].sc  <= (i > 0) ? accum(ser_q[i].sc, ser_q[i].tc, 1'(i % 2)) : ser_q[i].sc;
        mul_q[i].ps  <= pp_mul(ser_q[i].ts, ser_q[i].x2);
        mul_q[i].pc  <= pp_mul(ser_q[i].tc, ser_q[i].x2);

        prod_q[i].ctl <= mul_q[i].ctl;
        prod_q[i].x2  <= mul_q[i].x2;
        prod_q[i].ss  <= mul_q[i].ss;
        prod_q[i].sc  <= mul_q[i].sc;
        prod_q[i].ms  <= pp_shr(mul_q[i].ps, 62);
        prod_q[i].mc  <= pp_shr(mul_q[i].pc, 62);

        qpp_q[i].p  <= prod_q[i];
        qpp_q[i].ps <= pp_mul(prod_q[i].ms, rope_sc_pkg::SIN_MAGIC[i]);
        qpp_q[i].pc <= pp_mul(prod_q[i].mc, rope_sc_pkg::COS_MAGIC[i]);

        quo_q[i].p  <= qpp_q[i].p;
        quo_q[i].qs <= pp_shr(qpp_q[i].ps, 64);
        quo_q[i].qc <= pp_shr(qpp_q[i].pc, 64);

        ser_q[i+1].ctl <= quo_q[i].p.ctl;
        ser_q[i+1].x2  <= quo_q[i].p.x2;
        ser_q[i+1].ss  <= quo_q[i].p.ss;
        ser_q[i+1].sc  <= quo_q[i].p.sc;
        ser_q[i+1].ts  <= correct(quo_q[i].qs, quo_q[i].p.ms, rope_sc_pkg::SIN_DIV[i]);
        ser_q[i+1].tc  <= correct(quo_q[i].qc, quo_q[i].p.mc, rope_sc_pkg::COS_DIV[i]);
      end

      acc_q.ctl <= ser_q[rope_sc_pkg::NTERMS].ctl;
      acc_q.ss  <= accum(ser_q[rope_sc_pkg::NTERMS].ss, ser_q[rope_sc_pkg::NTERMS].ts, LAST_SUB);
      acc_q.sc  <= accum(ser_q[rope_sc_pkg::NTERMS].sc, ser_q[rope_sc_pkg::NTERMS].tc, LAST_SUB);

      rnd_q.vld  <= acc_q.ctl.vld;
      rnd_q.didx <= acc_q.ctl.didx;
      rnd_q.cm   <= 17'((cm_mag + ROUND_HALF) >> 47);
      rnd_q.cn   <= cm_neg;
      rnd_q.sm   <= 17'((sm_mag + ROUND_HALF) >> 47);
      rnd_q.sn   <= sm_neg;

      out_vld_q <= rnd_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      freq_idx_q <= rope_sc_pkg::FREQ_IDX_W'(rnd_q.didx);
      cos_q      <= to_q15(rnd_q.cm, rnd_q.cn);
      sin_q      <= to_q15(rnd_q.sm, rnd_q.sn);
      last_q     <= (rnd_q.didx == rope_sc_pkg::LAST_DIDX);
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.freq_index  = freq_idx_q;
  assign res_o.cos_value   = cos_q;
  assign res_o.sin_value   = sin_q;
  assign res_o.last_of_row = last_q;

`ifndef SYNTHESIS
  a_row_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> busy_q && (didx_q == '0))
    else $error("row does not start at frequency zero");

  a_counter_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !en && !in_fire |=> $stable(didx_q) && busy_q)
    else $error("frequency counter moved during a stall");

  a_pipe_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_o.ready |=> $stable(rnd_q) && $stable(acc_q))
    else $error("pipeline advanced while the result was stalled");

  a_last_matches_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.last_of_row ==
      (res_o.freq_index == rope_sc_pkg::FREQ_IDX_W'(rope_sc_pkg::HALF_DIM - 1))))
    else $error("last_of_row disagrees with the frequency index");
`endif

endmodule
